/* sv/cda_pkg.sv */
// shared constants, types and tables for the calendar date arithmetic block
`timescale 1ns / 1ps
package cda_pkg;

    localparam logic [13:0] YEAR_MAX = 14'd9999;
    localparam logic [17:0] ERA_DAYS = 18'd146097;
    localparam int          DIFF_MAX = 4194303;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_DIFF = 1'b1;

    // reciprocals rounded up, exact floor division over the operand range in use
    localparam logic [15:0] R100   = 16'(((64'd1 << 22) + 64'd99) / 64'd100);
    localparam logic [23:0] R_ERA  = 24'(((64'd1 << 41) + 64'd146096) / 64'd146097);
    localparam logic [18:0] R1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] R36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] R365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  RY100  = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] R153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    typedef struct packed {
        logic               op;
        logic               bad;
        logic signed [23:0] diff;
    } side_t;

    // days before the start of a month, months counted from march
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] off;
        begin
            case (mp)
                4'd0:    off = 9'd0;
                4'd1:    off = 9'd31;
                4'd2:    off = 9'd61;
                4'd3:    off = 9'd92;
                4'd4:    off = 9'd122;
                4'd5:    off = 9'd153;
                4'd6:    off = 9'd184;
                4'd7:    off = 9'd214;
                4'd8:    off = 9'd245;
                4'd9:    off = 9'd275;
                4'd10:   off = 9'd306;
                4'd11:   off = 9'd337;
                default: off = 9'd0;
            endcase
            return off;
        end
    endfunction

endpackage

/* sv/cda_to_serial.sv */
// three-stage conversion of a date to its day serial number
`timescale 1ns / 1ps
module cda_to_serial
    import cda_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [13:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    output logic [22:0] serial
);

    logic [14:0] yy_reg, yy_next;
    logic [8:0]  doy_reg, doy_next;
    logic [3:0]  mp;
    logic [30:0] p100;
    logic [23:0] y365_reg, y365_next;
    logic [8:0]  q100_reg, q100_next;
    logic [12:0] q4_reg, q4_next;
    logic [8:0]  doy2_reg;
    logic [23:0] sum;
    logic [22:0] serial_reg, serial_next;

    // year shifted up one era, january and february belong to the year before
    always_comb
    begin
        yy_next  = 15'(year) + 15'd400 - ((month <= 4'd2) ? 15'd1 : 15'd0);
        mp       = (month >= 4'd3) ? (month - 4'd3) : (month + 4'd9);
        doy_next = month_offset(mp) + 9'(day) - 9'd1;
    end

    always_comb
    begin
        p100      = 31'(yy_reg) * 31'(R100);
        q100_next = p100[30:22];
        y365_next = 24'(yy_reg) * 24'd365;
        q4_next   = yy_reg[14:2];
    end

    always_comb
    begin
        sum = y365_reg + 24'(q4_reg) - 24'(q100_reg) + 24'(q100_reg[8:2]) + 24'(doy2_reg);
        serial_next = sum[22:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yy_reg     <= yy_next;
            doy_reg    <= doy_next;
            y365_reg   <= y365_next;
            q100_reg   <= q100_next;
            q4_reg     <= q4_next;
            doy2_reg   <= doy_reg;
            serial_reg <= serial_next;
        end
    end

    assign serial = serial_reg;

endmodule

/* sv/cda_from_serial.sv */
// seven-stage conversion of a day serial number back to year, month and day
`timescale 1ns / 1ps
module cda_from_serial
    import cda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  side_t       in_side,
    input  logic [22:0] z,
    output logic        out_valid,
    output side_t       out_side,
    output logic [15:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day
);

    localparam int NSTG = 7;

    logic [NSTG-1:0] vld_reg;
    side_t           side_reg [NSTG];

    logic [22:0] z1_reg;
    logic [5:0]  era1_reg, era2_reg, era3_reg, era4_reg, era5_reg, era6_reg;
    logic [17:0] doe2_reg, doe3_reg, doe4_reg;
    logic [17:0] t3_reg;
    logic [8:0]  yoe4_reg, yoe5_reg, yoe6_reg;
    logic [8:0]  doy5_reg, doy6_reg;
    logic [3:0]  mp6_reg;
    logic [15:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    logic [46:0] p_era;
    logic [22:0] doe_full;
    logic [36:0] p1460, p36524, p365;
    logic [17:0] t_next;
    logic [18:0] py100;
    logic [17:0] doy_full;
    logic [10:0] x153;
    logic [22:0] p153;
    logic [3:0]  mm;
    logic [8:0]  d_full;
    logic [15:0] y_full;

    always_comb
    begin
        p_era    = 47'(z) * 47'(R_ERA);
        doe_full = z1_reg - 23'(era1_reg) * 23'(ERA_DAYS);
        p1460    = 37'(doe2_reg) * 37'(R1460);
        p36524   = 37'(doe2_reg) * 37'(R36524);
        t_next   = doe2_reg - 18'(p1460[36:29]) + 18'(p36524[36:34])
                 - ((doe2_reg == 18'(ERA_DAYS - 18'd1)) ? 18'd1 : 18'd0);
        p365     = 37'(t3_reg) * 37'(R365);
        py100    = 19'(yoe4_reg) * 19'(RY100);
        doy_full = doe4_reg - (18'(yoe4_reg) * 18'd365 + 18'(yoe4_reg[8:2])
                 - 18'(py100[18:16]));
        x153     = (11'(doy5_reg) << 2) + 11'(doy5_reg) + 11'd2;
        p153     = 23'(x153) * 23'(R153);
        mm       = (mp6_reg < 4'd10) ? (mp6_reg + 4'd3) : (mp6_reg - 4'd9);
        d_full   = doy6_reg - month_offset(mp6_reg) + 9'd1;
        y_full   = 16'(yoe6_reg) + 16'(era6_reg) * 16'd400
                 + ((mm <= 4'd2) ? 16'd1 : 16'd0) - 16'd400;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int i = 1; i < NSTG; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            z1_reg    <= z;
            era1_reg  <= p_era[46:41];
            era2_reg  <= era1_reg;
            doe2_reg  <= doe_full[17:0];
            era3_reg  <= era2_reg;
            doe3_reg  <= doe2_reg;
            t3_reg    <= t_next;
            era4_reg  <= era3_reg;
            doe4_reg  <= doe3_reg;
            yoe4_reg  <= p365[35:27];
            era5_reg  <= era4_reg;
            yoe5_reg  <= yoe4_reg;
            doy5_reg  <= doy_full[8:0];
            era6_reg  <= era5_reg;
            yoe6_reg  <= yoe5_reg;
            doy6_reg  <= doy5_reg;
            mp6_reg   <= p153[22:19];
            year_reg  <= y_full;
            month_reg <= mm;
            day_reg   <= d_full[4:0];
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];
    assign year      = year_reg;
    assign month     = month_reg;
    assign day       = day_reg;

endmodule

/* sv/calendar_date_arithmetic.sv */
// top level of the gregorian date add and difference unit
`timescale 1ns / 1ps
// Gregorian date arithmetic over a stream. The slave transfer carries one request:
// tuser selects add (0: date A plus days_to_add) or difference (1: days from date B
// to date A). Both dates are turned into day serial numbers, added or subtracted,
// and for an add the sum is turned back into a calendar date. The pipeline is
// twelve register stages deep and takes a new transfer every cycle while the
// master side is not stalled, and a master stall holds the whole pipeline, so
// nothing is dropped or repeated. Status 1 flags a month outside 1..12 or a day
// outside 1..31 (other fields zero), status 2 flags an add result past 9999-12-31
// (saturated to that date) or a difference beyond +-4194303 (saturated). Day
// numbers too large for their month are accepted and carry into the following
// months.
module calendar_date_arithmetic
    import cda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year_a[13:0], month_a[17:14], day_a[22:18], days_to_add[38:23],
    // year_b[52:39], month_b[56:53], day_b[61:57], zero fill [63:62]
    input  logic [63:0] s_tdata,
    // op[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_year[13:0], result_month[17:14], result_day[22:18],
    // day_difference[45:23], status[47:46]
    output logic [47:0] m_tdata
);

    localparam int LAT_SER = 3;

    // input field split
    logic [13:0] year_a, year_b;
    logic [3:0]  month_a, month_b;
    logic [4:0]  day_a, day_b;
    logic [15:0] days_to_add;
    logic        bad_in;

    // pipeline advance, the whole pipe holds while a result waits
    logic en;

    // sideband delay alongside the serial conversion
    logic [LAT_SER-1:0] vs_reg;
    logic               ops_reg  [LAT_SER];
    logic               bads_reg [LAT_SER];
    logic [15:0]        ns_reg   [LAT_SER];

    logic [22:0] ser_a, ser_b;

    // sum and difference stage
    logic               v4_reg;
    side_t              side4_reg;
    logic [22:0]        z4_reg;
    logic [23:0]        zsum;

    // back conversion
    logic        vf;
    side_t       sidef;
    logic [15:0] yf;
    logic [3:0]  mf;
    logic [4:0]  df;

    // output register
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg, m_tdata_next;
    logic [13:0] ry;
    logic [3:0]  rm;
    logic [4:0]  rd;
    logic [22:0] rdiff;
    logic [1:0]  rst_code;

    assign year_a      = s_tdata[13:0];
    assign month_a     = s_tdata[17:14];
    assign day_a       = s_tdata[22:18];
    assign days_to_add = s_tdata[38:23];
    assign year_b      = s_tdata[52:39];
    assign month_b     = s_tdata[56:53];
    assign day_b       = s_tdata[61:57];

    // date B only matters for a difference
    assign bad_in = (month_a < 4'd1) || (month_a > 4'd12) || (day_a < 5'd1)
                 || ((s_tuser == OP_DIFF)
                     && ((month_b < 4'd1) || (month_b > 4'd12) || (day_b < 5'd1)));

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    cda_to_serial u_ser_a (
        .clk    (clk),
        .en     (en),
        .year   (year_a),
        .month  (month_a),
        .day    (day_a),
        .serial (ser_a)
    );

    cda_to_serial u_ser_b (
        .clk    (clk),
        .en     (en),
        .year   (year_b),
        .month  (month_b),
        .day    (day_b),
        .serial (ser_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg <= '0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            vs_reg <= {vs_reg[LAT_SER-2:0], s_tvalid};
            v4_reg <= vs_reg[LAT_SER-1];
        end
    end

    assign zsum = 24'(ser_a) + 24'(ns_reg[LAT_SER-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ops_reg[0]  <= s_tuser;
            bads_reg[0] <= bad_in;
            ns_reg[0]   <= days_to_add;
            for (int i = 1; i < LAT_SER; i++)
            begin
                ops_reg[i]  <= ops_reg[i-1];
                bads_reg[i] <= bads_reg[i-1];
                ns_reg[i]   <= ns_reg[i-1];
            end
            side4_reg.op   <= ops_reg[LAT_SER-1];
            side4_reg.bad  <= bads_reg[LAT_SER-1];
            side4_reg.diff <= $signed({1'b0, ser_a}) - $signed({1'b0, ser_b});
            z4_reg         <= zsum[22:0];
        end
    end

    cda_from_serial u_from (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_side   (side4_reg),
        .z         (z4_reg),
        .out_valid (vf),
        .out_side  (sidef),
        .year      (yf),
        .month     (mf),
        .day       (df)
    );

    // result selection, saturation and status
    always_comb
    begin
        ry       = '0;
        rm       = '0;
        rd       = '0;
        rdiff    = '0;
        rst_code = ST_OK;
        if (sidef.bad)
        begin
            rst_code = ST_BAD;
        end
        else if (sidef.op == OP_ADD)
        begin
            if (yf > 16'(YEAR_MAX))
            begin
                ry       = YEAR_MAX;
                rm       = 4'd12;
                rd       = 5'd31;
                rst_code = ST_SAT;
            end
            else
            begin
                ry = yf[13:0];
                rm = mf;
                rd = df;
            end
        end
        else
        begin
            if (sidef.diff > 24'(DIFF_MAX))
            begin
                rdiff    = 23'(DIFF_MAX);
                rst_code = ST_SAT;
            end
            else if (sidef.diff < -24'(DIFF_MAX))
            begin
                rdiff    = 23'(-DIFF_MAX);
                rst_code = ST_SAT;
            end
            else
            begin
                rdiff = sidef.diff[22:0];
            end
        end
        m_tdata_next = {rst_code, rdiff, rd, rm, ry};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= vf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
